// ===== hdl/positional_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Short forms for the concurrent checks of the top level. They sample on the
// rising edge of clock and are switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Antecedent holds, so the consequent must hold in the same cycle.
`define PLC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds, so the consequent must hold in the next cycle.
`define PLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, command and status codes, and the control word that is broadcast
// to every cell of the storage chain.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

   // List size and the widths that follow from it.
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the channels.
   localparam int CMD_W  = 3;
   localparam int POS_W  = 6;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;

   // Width used to compare a position against the count.
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 3'd0,
      CMD_REMOVE  = 3'd1,
      CMD_READ    = 3'd2,
      CMD_REVERSE = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   // Control word seen by every cell in the same cycle.
   typedef struct packed {
      logic                     ins;
      logic                     rmv;
      logic [IDX_W-1:0]         addr;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit entries with insert, remove and read at a
// position, reverse and clear, kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one command per beat (req_cmd, req_pos,
//   req_value). The rsp_ channel returns exactly one beat per command with
//   the read value, a status code, the entry count and an empty flag.
//   All cells shift at once, so the list is updated at the accepting edge
//   and the result is registered at that same edge. Throughput is one
//   command per cycle as long as the receiver takes results; the output
//   register is the only stage.
//   Reverse does not move data: it flips an orientation bit, and later
//   positions are mapped through it onto the physical cells.
//   When the receiver stalls, the pending result holds and req_ready stays
//   low until it is taken; no command is lost or dropped.
//   Reset empties the list (count zero, forward orientation), holds req_ready
//   low and clears rsp_valid. Entry storage is not cleared; only written
//   entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [plc_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [plc_pkg::POS_W-1:0]         req_pos,
   input  wire logic signed [plc_pkg::DATA_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [plc_pkg::DATA_W-1:0]      rsp_read_value,
   output logic [plc_pkg::STAT_W-1:0]             rsp_status,
   output logic [plc_pkg::CNT_W-1:0]              rsp_entry_count,
   output logic                                   rsp_is_empty
);
   import plc_pkg::*;

   `include "positional_list_engine_assert.svh"

   // State.
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rev_ff, rev_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_entry_count_ff;

   // Decode signals.
   logic                     accept;
   logic [CMP_W-1:0]         pos_x, cnt_x, ins_x, rmv_x;
   logic [IDX_W-1:0]         ins_idx, rmv_idx;
   logic signed [DATA_W-1:0] rd_value;
   cell_ctl_type             ctl;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Map a logical position onto a physical cell; a reversed list is stored
   // with its first entry in the highest used cell.
   always_comb begin
      pos_x   = CMP_W'(req_pos);
      cnt_x   = CMP_W'(count_ff);
      ins_x   = cnt_x - pos_x;
      rmv_x   = cnt_x - pos_x - CMP_W'(1);
      ins_idx = rev_ff ? IDX_W'(ins_x) : IDX_W'(pos_x);
      rmv_idx = rev_ff ? IDX_W'(rmv_x) : IDX_W'(pos_x);
   end

   // Command decode: next count, orientation, cell control and result.
   always_comb begin
      count_in          = count_ff;
      rev_in            = rev_ff;
      rsp_status_in     = ST_OK;
      rsp_read_value_in = '0;
      ctl.ins           = 1'b0;
      ctl.rmv           = 1'b0;
      ctl.addr          = ins_idx;
      ctl.value         = req_value;
      unique case (cmd_type'(req_cmd))
         CMD_INSERT: begin
            if (pos_x > cnt_x) begin
               rsp_status_in = ST_BADPOS;
            end else if (count_ff == CAP_COUNT) begin
               rsp_status_in = ST_FULL;
            end else begin
               ctl.ins  = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            ctl.addr = rmv_idx;
            if (pos_x >= cnt_x) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               ctl.rmv  = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_READ: begin
            if (pos_x >= cnt_x) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               rsp_read_value_in = rd_value;
            end
         end
         CMD_REVERSE: begin
            rev_in = !rev_ff;
         end
         CMD_CLEAR: begin
            count_in = '0;
            rev_in   = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Storage chain.
   plc_chain u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .rd_idx   (rmv_idx),
      .rd_value (rd_value)
   );

   // Result beat stays until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
            rev_ff   <= rev_in;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff  <= rsp_read_value_in;
         rsp_status_ff      <= rsp_status_in;
         rsp_entry_count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = (rsp_entry_count_ff == '0);

   // Checks.
   `PLC_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CAP_COUNT, "count above capacity")
   `PLC_ASSERT_NEXT(a_count_hold, !accept, $stable(count_ff), "count moved without a beat")
   `PLC_ASSERT_SAME(a_err_zero, rsp_valid_ff && (rsp_status_ff != ST_OK),
      rsp_read_value_ff == '0, "failed command returned a read value")
   `PLC_ASSERT_NEXT(a_rsp_count, accept, rsp_entry_count_ff == count_ff,
      "result count differs from list count")

endmodule

`default_nettype wire

// ===== hdl/plc_cell.sv =====
// ----------------------------------------------------------------------------
// Positional list storage cell
// Holds one entry. On an insert it takes the new value or its lower
// neighbor's entry; on a remove it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_cell (
   input  wire logic                             clock,
   input  wire plc_pkg::cell_ctl_type            ctl,
   input  wire logic [plc_pkg::IDX_W-1:0]        cell_idx,
   input  wire logic signed [plc_pkg::DATA_W-1:0] left_q,
   input  wire logic signed [plc_pkg::DATA_W-1:0] right_q,
   output logic signed [plc_pkg::DATA_W-1:0]     entry_q
);
   import plc_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   // Cells above the insert point move up, cells at or above the remove
   // point move down, everything else holds.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (cell_idx == ctl.addr) begin
            entry_in = ctl.value;
         end else if (cell_idx > ctl.addr) begin
            entry_in = left_q;
         end
      end else if (ctl.rmv && (cell_idx >= ctl.addr)) begin
         entry_in = right_q;
      end
   end

   // Payload only: contents are undefined until written.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

`default_nettype wire

// ===== hdl/plc_chain.sv =====
// ----------------------------------------------------------------------------
// Positional list storage chain
// A row of CAPACITY cells linked to their neighbors, plus the read select
// that picks one physical entry.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_chain (
   input  wire logic                              clock,
   input  wire plc_pkg::cell_ctl_type             ctl,
   input  wire logic [plc_pkg::IDX_W-1:0]         rd_idx,
   output logic signed [plc_pkg::DATA_W-1:0]      rd_value
);
   import plc_pkg::*;

   logic signed [DATA_W-1:0] cell_q  [CAPACITY];
   logic signed [DATA_W-1:0] left_d  [CAPACITY];
   logic signed [DATA_W-1:0] right_d [CAPACITY];

   // Neighbor links; the ends of the row feed back their own entry.
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
         assign left_d[gi] = cell_q[gi];
      end else begin : g_left
         assign left_d[gi] = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
         assign right_d[gi] = cell_q[gi];
      end else begin : g_right
         assign right_d[gi] = cell_q[gi+1];
      end

      plc_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .cell_idx (IDX_W'(gi)),
         .left_q   (left_d[gi]),
         .right_q  (right_d[gi]),
         .entry_q  (cell_q[gi])
      );
   end

   // Read select over the whole row.
   assign rd_value = cell_q[rd_idx];

endmodule

`default_nettype wire
